/* hdl/rro_pkg.sv */
package rro_pkg;

  localparam int SIDE_BITS_DEF  = 12;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int ANGLE_BITS_DEF = 16;

  // quotient bits resolved per divider stage
  localparam int DIV_PER_STAGE = 4;
  localparam int NUM_TERMS     = 7;

  localparam logic [30:0] PIH_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // series divisors and floor(2^32 / d) reciprocals
  localparam logic [7:0] SIN_DIV [NUM_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72,
                                                  8'd110, 8'd156, 8'd210};
  localparam logic [7:0] COS_DIV [NUM_TERMS] = '{8'd2, 8'd12, 8'd30, 8'd56,
                                                  8'd90, 8'd132, 8'd182};
  localparam logic [31:0] SIN_RCP [NUM_TERMS] = '{32'd715827882, 32'd214748364,
                                                   32'd102261126, 32'd59652323,
                                                   32'd39045157, 32'd27531841,
                                                   32'd20452225};
  localparam logic [31:0] COS_RCP [NUM_TERMS] = '{32'd2147483648, 32'd357913941,
                                                   32'd143165576, 32'd76695844,
                                                   32'd47721858, 32'd32537631,
                                                   32'd23598721};

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_RAD_TL = 3'd2;
  localparam logic [2:0] REG_RAD_TR = 3'd3;
  localparam logic [2:0] REG_RAD_BR = 3'd4;
  localparam logic [2:0] REG_RAD_BL = 3'd5;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

endpackage

/* hdl/rro_req_if.sv */
interface rro_req_if import rro_pkg::*; #(
  parameter int SIDE_BITS = SIDE_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [SIDE_BITS+1:0] point_index;

  modport source (output valid, output point_index, input ready);
  modport sink   (input valid, input point_index, output ready);
endinterface

/* hdl/rro_rsp_if.sv */
interface rro_rsp_if import rro_pkg::*; #(
  parameter int SIDE_BITS = SIDE_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic [SIDE_BITS+FRAC_BITS-1:0] point_x;
  logic [SIDE_BITS+FRAC_BITS-1:0] point_y;
  logic [1:0]                     corner_id;
  logic                           index_valid;
  logic [SIDE_BITS+1:0]           total_points;

  modport source (output valid, output point_x, output point_y, output corner_id,
                  output index_valid, output total_points, input ready);
  modport sink   (input valid, input point_x, input point_y, input corner_id,
                  input index_valid, input total_points, output ready);
endinterface

/* hdl/rounded_rect_outline_point.sv */
// Throughput: one request per cycle; the pipeline advances whenever its last
// stage is empty or the result is taken, so a stall freezes every stage.
// The angle divider resolves four quotient bits per stage; each of the seven
// series terms takes three stages (multiply, reciprocal multiply, correct).
// Reset clears the stage valid bits and all configuration registers to zero.
module rounded_rect_outline_point import rro_pkg::*; #(
  parameter int SIDE_BITS  = SIDE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rro_req_if.sink     req_i,
  rro_rsp_if.source   rsp_o
);

  localparam int SB  = SIDE_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int AB  = ANGLE_BITS;
  localparam int QW  = SIDE_BITS + 32;
  localparam int DS  = (AB + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
  localparam int NST = DS + 26;
  localparam int S_X   = DS + 1;
  localparam int S_X2  = DS + 2;
  localparam int S_SER = DS + 3;
  localparam int S_DXY = DS + 24;
  localparam int S_OUT = DS + 25;

  typedef struct packed {
    logic               found;
    logic [1:0]         corner;
    logic [SB-2:0]      r;
    logic [SB-1:0]      n;
    logic [SB+1:0]      total;
    logic [SB-1:0]      rem;
    logic [AB-1:0]      theta;
    logic [31:0]        x;
    logic [31:0]        x2;
    logic [31:0]        ts;
    logic [31:0]        tc;
    logic [63:0]        ps;
    logic [63:0]        pc;
    logic [31:0]        vs;
    logic [31:0]        vc;
    logic signed [34:0] ss;
    logic signed [34:0] sc;
    logic [QW-1:0]      dx;
    logic [QW-1:0]      dy;
    logic [SB+FB-1:0]   px;
    logic [SB+FB-1:0]   py;
  } stage_t;

  // ---------------- configuration ----------------
  logic [SB-1:0] width_q, height_q;
  logic [SB-2:0] rad_q [4];
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      for (int i = 0; i < 4; i++) rad_q[i] <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_WIDTH:  width_q  <= pwdata[SB-1:0];
        REG_HEIGHT: height_q <= pwdata[SB-1:0];
        REG_RAD_TL: rad_q[0] <= pwdata[SB-2:0];
        REG_RAD_TR: rad_q[1] <= pwdata[SB-2:0];
        REG_RAD_BR: rad_q[2] <= pwdata[SB-2:0];
        REG_RAD_BL: rad_q[3] <= pwdata[SB-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      REG_RAD_TL: prdata = 32'(rad_q[0]);
      REG_RAD_TR: prdata = 32'(rad_q[1]);
      REG_RAD_BR: prdata = 32'(rad_q[2]);
      REG_RAD_BL: prdata = 32'(rad_q[3]);
      default:    prdata = '0;
    endcase
  end

  // clamp each radius to both half sides
  logic [SB-2:0] rc [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rc[c] = rad_q[c];
      if (rc[c] > width_q[SB-1:1])  rc[c] = width_q[SB-1:1];
      if (rc[c] > height_q[SB-1:1]) rc[c] = height_q[SB-1:1];
    end
  end

  // ---------------- pipeline ----------------
  logic [NST-1:0] vld_q;
  stage_t         pay_q [NST];
  stage_t         pay_d [NST];
  logic           adv;

  assign adv         = ~vld_q[NST-1] | rsp_o.ready;
  assign req_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NST; i++) pay_q[i] <= pay_d[i];
    end
  end

  // decode: locate corner and point within corner
  always_comb begin
    logic [SB+1:0] cum1, cum2, cum3, tot, base, idx;
    logic [1:0]    cn;
    pay_d[0] = '0;
    idx  = req_i.point_index;
    cum1 = (SB+2)'({rc[0], 1'b1});
    cum2 = cum1 + (SB+2)'({rc[1], 1'b1});
    cum3 = cum2 + (SB+2)'({rc[2], 1'b1});
    tot  = cum3 + (SB+2)'({rc[3], 1'b1});
    if (idx < cum1) begin
      cn = CORNER_TL; base = '0;
    end else if (idx < cum2) begin
      cn = CORNER_TR; base = cum1;
    end else if (idx < cum3) begin
      cn = CORNER_BR; base = cum2;
    end else begin
      cn = CORNER_BL; base = cum3;
    end
    pay_d[0].found  = idx < tot;
    pay_d[0].corner = cn;
    pay_d[0].r      = rc[cn];
    pay_d[0].n      = {rc[cn], 1'b1};
    pay_d[0].total  = tot;
    pay_d[0].rem    = pay_d[0].found ? SB'(idx - base) : '0;
  end

  // restoring divider: theta = (p << AB) / n
  for (genvar j = 0; j < DS; j++) begin : g_div
    always_comb begin
      logic [SB:0] rem2;
      logic [SB:0] diff;
      pay_d[1+j] = pay_q[j];
      for (int t = 0; t < DIV_PER_STAGE; t++) begin
        rem2 = {pay_d[1+j].rem, 1'b0};
        diff = rem2 - {1'b0, pay_d[1+j].n};
        if (j * DIV_PER_STAGE + t < AB) begin
          if (rem2 >= {1'b0, pay_d[1+j].n}) begin
            pay_d[1+j].rem   = diff[SB-1:0];
            pay_d[1+j].theta = {pay_d[1+j].theta[AB-2:0], 1'b1};
          end else begin
            pay_d[1+j].rem   = rem2[SB-1:0];
            pay_d[1+j].theta = {pay_d[1+j].theta[AB-2:0], 1'b0};
          end
        end
      end
    end
  end

  // radians in Q30
  always_comb begin
    logic [AB+30:0] tx;
    pay_d[S_X] = pay_q[S_X-1];
    tx = (AB+31)'(pay_q[S_X-1].theta) * (AB+31)'(PIH_Q30);
    pay_d[S_X].x = {1'b0, tx[AB+30:AB]};
  end

  always_comb begin
    logic [63:0] xx;
    pay_d[S_X2] = pay_q[S_X2-1];
    xx = 64'(pay_q[S_X2-1].x) * 64'(pay_q[S_X2-1].x);
    pay_d[S_X2].x2 = xx[61:30];
    pay_d[S_X2].ts = pay_q[S_X2-1].x;
    pay_d[S_X2].tc = 32'(ONE_Q30);
    pay_d[S_X2].ss = 35'(pay_q[S_X2-1].x);
    pay_d[S_X2].sc = 35'(ONE_Q30);
  end

  // series terms: multiply, reciprocal multiply, correct and accumulate
  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_ser
    localparam int B = S_SER + 3 * k;

    always_comb begin
      pay_d[B]    = pay_q[B-1];
      pay_d[B].ps = 64'(pay_q[B-1].ts) * 64'(pay_q[B-1].x2);
      pay_d[B].pc = 64'(pay_q[B-1].tc) * 64'(pay_q[B-1].x2);
    end

    always_comb begin
      pay_d[B+1]    = pay_q[B];
      pay_d[B+1].vs = pay_q[B].ps[61:30];
      pay_d[B+1].vc = pay_q[B].pc[61:30];
      pay_d[B+1].ps = 64'(pay_q[B].ps[61:30]) * 64'(SIN_RCP[k]);
      pay_d[B+1].pc = 64'(pay_q[B].pc[61:30]) * 64'(COS_RCP[k]);
    end

    always_comb begin
      logic [31:0] qs, qc;
      logic [39:0] rs, rcs;
      pay_d[B+2] = pay_q[B+1];
      qs  = pay_q[B+1].ps[63:32];
      qc  = pay_q[B+1].pc[63:32];
      rs  = 40'(pay_q[B+1].vs) - 40'(qs) * 40'(SIN_DIV[k]);
      rcs = 40'(pay_q[B+1].vc) - 40'(qc) * 40'(COS_DIV[k]);
      // reciprocal estimate is at most one low
      if (rs >= 40'(SIN_DIV[k]))  qs = qs + 32'd1;
      if (rcs >= 40'(COS_DIV[k])) qc = qc + 32'd1;
      pay_d[B+2].ts = qs;
      pay_d[B+2].tc = qc;
      if (k % 2 == 0) begin
        pay_d[B+2].ss = pay_q[B+1].ss - $signed({3'b000, qs});
        pay_d[B+2].sc = pay_q[B+1].sc - $signed({3'b000, qc});
      end else begin
        pay_d[B+2].ss = pay_q[B+1].ss + $signed({3'b000, qs});
        pay_d[B+2].sc = pay_q[B+1].sc + $signed({3'b000, qc});
      end
    end
  end

  // clamp sums to [0, 1] and scale by radius
  always_comb begin
    logic [30:0] sn, cs;
    pay_d[S_DXY] = pay_q[S_DXY-1];
    if (pay_q[S_DXY-1].ss[34])                      sn = '0;
    else if (pay_q[S_DXY-1].ss > 35'(ONE_Q30))      sn = ONE_Q30;
    else                                            sn = pay_q[S_DXY-1].ss[30:0];
    if (pay_q[S_DXY-1].sc[34])                      cs = '0;
    else if (pay_q[S_DXY-1].sc > 35'(ONE_Q30))      cs = ONE_Q30;
    else                                            cs = pay_q[S_DXY-1].sc[30:0];
    pay_d[S_DXY].dx = QW'(cs) * QW'(pay_q[S_DXY-1].r);
    pay_d[S_DXY].dy = QW'(sn) * QW'(pay_q[S_DXY-1].r);
  end

  // place in corner and round to nearest
  always_comb begin
    logic [QW-1:0] rq, wq, hq, vx, vy, half;
    stage_t        s;
    s    = pay_q[S_OUT-1];
    rq   = QW'(s.r) << 30;
    wq   = QW'(width_q) << 30;
    hq   = QW'(height_q) << 30;
    half = QW'(1) << (29 - FB);
    case (s.corner)
      CORNER_TL: begin vx = rq - s.dx;      vy = rq - s.dy;      end
      CORNER_TR: begin vx = wq - rq + s.dy; vy = rq - s.dx;      end
      CORNER_BR: begin vx = wq - rq + s.dx; vy = hq - rq + s.dy; end
      default:   begin vx = rq - s.dy;      vy = hq - rq + s.dx; end
    endcase
    vx = vx + half;
    vy = vy + half;
    pay_d[S_OUT] = s;
    pay_d[S_OUT].px = s.found ? vx[SB+29:30-FB] : '0;
    pay_d[S_OUT].py = s.found ? vy[SB+29:30-FB] : '0;
    pay_d[S_OUT].corner = s.found ? s.corner : CORNER_TL;
  end

  assign rsp_o.valid        = vld_q[NST-1];
  assign rsp_o.point_x      = pay_q[NST-1].px;
  assign rsp_o.point_y      = pay_q[NST-1].py;
  assign rsp_o.corner_id    = pay_q[NST-1].corner;
  assign rsp_o.index_valid  = pay_q[NST-1].found;
  assign rsp_o.total_points = pay_q[NST-1].total;

  // ---------------- assertions ----------------
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> pay_q[0].rem < pay_q[0].n)
    else $error("divider start remainder not below divisor");

  a_rad_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (pay_q[0].r <= width_q[SB-1:1]) && (pay_q[0].r <= height_q[SB-1:1]))
    else $error("radius exceeds half side");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST-1] && !pay_q[NST-1].found) |->
      (pay_q[NST-1].px == '0) && (pay_q[NST-1].py == '0) && (pay_q[NST-1].corner == '0))
    else $error("out of range request carries nonzero point");

  a_stall_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST-1] && !rsp_o.ready) |=> vld_q[NST-1] && $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule
